>>> hw/rtl/coi_pkg.sv
// ----------------------------------------------------------------------------
// coi_pkg: shared types, constants and microcode for the cooling integrator
// Holds Q8.24 widths, register indexes, method codes, the micro-op table that
// drives the shared multiplier, and the saturation helpers.
// ----------------------------------------------------------------------------
package coi_pkg;

   // Q8.24 arithmetic
   localparam int QW    = 32;              // signed Q8.24 word
   localparam int PW    = 2 * QW;          // full product
   localparam int FRAC  = 24;              // fraction bits
   localparam int HW    = 31;              // step size / time width
   localparam int CW    = 16;              // step counter width
   localparam int MW    = 2;               // method code width
   localparam int SW    = 37;              // wide sums before saturation

   // Divide-by-six unit: radix-16 digits over the offset RK4 sum
   localparam int DIG_W      = 4;
   localparam int DIV_DIGITS = 9;
   localparam int DIV_W      = DIG_W * DIV_DIGITS;
   localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);

   // Offset that keeps the RK4 sum non-negative, and its share after / 6
   localparam logic signed [SW-1:0] RK4_BIAS = SW'(40'sh06_0000_0000);
   localparam logic signed [SW-1:0] INC_BIAS = SW'(40'sh01_0000_0000);

   localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic [HW-1:0]        T_MAX = 31'h7FFF_FFFF;

   // Configuration register indexes
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_METHOD = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ALPHA  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_BETA   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_STEP   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_ICOUNT = 3'd4;

   // Method codes
   localparam logic [MW-1:0] METH_EULER = 2'd0;
   localparam logic [MW-1:0] METH_HEUN  = 2'd1;
   localparam logic [MW-1:0] METH_MID   = 2'd2;
   localparam logic [MW-1:0] METH_RK4   = 2'd3;

   // Action codes on the request word
   localparam logic ACT_LOAD = 1'b0;

   // Micro-op program counter
   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] UPC_LAST = UPC_W'(16);

   typedef enum logic [2:0] {A_W, A_T, A_ALPHA, A_H, A_HH} asel_type;
   typedef enum logic [1:0] {B_W, B_T, B_F, B_CNT} bsel_type;
   typedef enum logic [3:0] {
      P_SQ, P_SUBB, P_NEG, P_NEGSUM, P_YNEW, P_HEUN1, P_MID1,
      P_K1, P_K2, P_K3, P_K4, P_TIME
   } post_type;

   typedef struct packed {
      asel_type asel;
      bsel_type bsel;
      post_type post;
      logic     done;
   } uop_type;

   function automatic uop_type uop_make(input asel_type a, input bsel_type b,
                                        input post_type p);
      uop_type u;
      u.asel = a;
      u.bsel = b;
      u.post = p;
      u.done = 1'b0;
      return u;
   endfunction

   // Derivative f(w) = -alpha * (w^4 - beta): three multiplies
   function automatic uop_type uop_deriv(input logic [1:0] k);
      uop_type u;
      case (k)
         2'd0:    u = uop_make(A_W, B_W, P_SQ);
         2'd1:    u = uop_make(A_T, B_T, P_SUBB);
         default: u = uop_make(A_ALPHA, B_T, P_NEG);
      endcase
      return u;
   endfunction

   // Closing op of every program: time = index * h
   function automatic uop_type uop_time();
      uop_type u;
      u = uop_make(A_H, B_CNT, P_TIME);
      u.done = 1'b1;
      return u;
   endfunction

   function automatic uop_type uop_fetch(input logic [MW-1:0] method,
                                         input logic [UPC_W-1:0] upc);
      uop_type u;
      u = uop_time();
      case (method)
         METH_EULER: begin
            if (upc < UPC_W'(3)) u = uop_deriv(upc[1:0]);
            else if (upc == UPC_W'(3)) u = uop_make(A_H, B_F, P_YNEW);
         end
         METH_HEUN: begin
            if (upc < UPC_W'(3)) u = uop_deriv(upc[1:0]);
            else if (upc == UPC_W'(3)) u = uop_make(A_H, B_F, P_HEUN1);
            else if (upc < UPC_W'(6)) u = uop_deriv(2'(upc - UPC_W'(4)));
            else if (upc == UPC_W'(6)) u = uop_make(A_ALPHA, B_T, P_NEGSUM);
            else if (upc == UPC_W'(7)) u = uop_make(A_HH, B_F, P_YNEW);
         end
         METH_MID: begin
            if (upc < UPC_W'(3)) u = uop_deriv(upc[1:0]);
            else if (upc == UPC_W'(3)) u = uop_make(A_HH, B_F, P_MID1);
            else if (upc < UPC_W'(7)) u = uop_deriv(2'(upc - UPC_W'(4)));
            else if (upc == UPC_W'(7)) u = uop_make(A_H, B_F, P_YNEW);
         end
         default: begin
            if (upc < UPC_LAST) begin
               if (upc[1:0] != 2'd3) begin
                  u = uop_deriv(upc[1:0]);
               end else begin
                  case (upc[3:2])
                     2'd0:    u = uop_make(A_H, B_F, P_K1);
                     2'd1:    u = uop_make(A_H, B_F, P_K2);
                     2'd2:    u = uop_make(A_H, B_F, P_K3);
                     default: u = uop_make(A_H, B_F, P_K4);
                  endcase
               end
            end
         end
      endcase
      return u;
   endfunction

   // Saturation of wide sums to the signed Q8.24 range
   function automatic logic ovf32(input logic signed [SW-1:0] v);
      return !((&v[SW-1:QW-1]) || !(|v[SW-1:QW-1]));
   endfunction

   function automatic logic signed [QW-1:0] sat32(input logic signed [SW-1:0] v);
      logic signed [QW-1:0] r;
      if (ovf32(v)) r = v[SW-1] ? Q_MIN : Q_MAX;
      else          r = v[QW-1:0];
      return r;
   endfunction

endpackage

>>> hw/rtl/coi_qmul.sv
// ----------------------------------------------------------------------------
// coi_qmul: shared Q8.24 multiplier
// Registers the full signed product, then floors away the fraction bits and
// saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module coi_qmul (
   input  logic                             clock,
   input  logic signed [coi_pkg::QW-1:0]    mul_a,
   input  logic signed [coi_pkg::QW-1:0]    mul_b,
   output logic signed [coi_pkg::PW-1:0]    prod,
   output logic signed [coi_pkg::QW-1:0]    q,
   output logic                             q_ovf
);
   import coi_pkg::*;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // floor(prod / 2^24) fits when the bits above its sign all agree
   assign q_ovf = !((&prod_ff[PW-1:FRAC+QW-1]) || !(|prod_ff[PW-1:FRAC+QW-1]));
   assign q     = q_ovf ? (prod_ff[PW-1] ? Q_MIN : Q_MAX) : prod_ff[FRAC+QW-1:FRAC];
   assign prod  = prod_ff;

endmodule

>>> hw/rtl/coi_div6.sv
// ----------------------------------------------------------------------------
// coi_div6: iterative divide by six
// Takes one radix-16 digit per cycle from a non-negative dividend; the
// quotient shifts in behind the dividend in the same register.
// ----------------------------------------------------------------------------
module coi_div6 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [coi_pkg::DIV_W-1:0]     num,
   output logic [coi_pkg::DIV_W-1:0]     quot,
   output logic                          done
);
   import coi_pkg::*;

   logic [DIV_W-1:0]     shreg_ff, shreg_in;
   logic [2:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [6:0]           part;
   logic [DIG_W-1:0]     digit;
   logic [6:0]           rdiff;

   always_comb begin
      part  = {rem_ff, shreg_ff[DIV_W-1 -: DIG_W]};
      digit = '0;
      for (int k = 1; k < 16; k++) begin
         if (part >= 7'(6 * k)) digit = digit + 4'd1;
      end
      rdiff = part - ({1'b0, digit, 2'b00} + {2'b00, digit, 1'b0});
   end

   always_comb begin
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shreg_in = num;
         rem_in   = '0;
         dcnt_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shreg_in = {shreg_ff[DIV_W-DIG_W-1:0], digit};
         rem_in   = rdiff[2:0];
         dcnt_in  = dcnt_ff + DIV_CNT_W'(1);
         if (dcnt_ff == DIV_CNT_W'(DIV_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         dcnt_ff <= dcnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign quot = shreg_ff;
   assign done = done_ff;

endmodule

>>> hw/rtl/cooling_ode_integrator.sv
// ----------------------------------------------------------------------------
// cooling_ode_integrator: fixed-step solver for dy/dt = -alpha*(y^4 - beta)
// Euler, Heun, midpoint or fourth-order Runge-Kutta in signed Q8.24, at most one
// step per request word, all products on one shared multiplier.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+----------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata y_start, tuser action
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata index,time,y; tlast; tuser sat
//   csr     | in  | csr_we                 | csr_index, csr_wdata
//
// A load or a step past the end of the run goes from idle straight to the
// finish state and into the output register. A step runs between the idle
// and finish states; each micro-op on the shared multiplier takes an issue
// state, then a floor/saturate/write-back state: Euler 5 ops, Heun and
// midpoint 9 ops, RK4 17 ops plus a divide-by-six before its closing op.
// The request side is ready only while idle; a finished word waits in the
// output register, so the next request is taken while rsp is stalled.
// Synchronous active-high reset clears state and the output valid and sets config to its defaults.
// ----------------------------------------------------------------------------
module cooling_ode_integrator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [31:0] y_start
   input  logic                          req_tuser,   // [0] action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [79:0]                   rsp_tdata,   // [15:0] step_index,
                                                      // [46:16] time_now,
                                                      // [78:47] y_value
   output logic                          rsp_tlast,   // last
   output logic                          rsp_tuser,   // [0] saturated
   input  logic                          csr_we,
   input  logic [coi_pkg::CSR_IW-1:0]    csr_index,
   input  logic [31:0]                   csr_wdata
);
   import coi_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_POST = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [UPC_W-1:0]     upc_ff, upc_in;

   // Configuration
   logic [MW-1:0]        method_ff;
   logic signed [QW-1:0] alpha_ff, beta_ff;
   logic [HW-1:0]        h_ff;
   logic [CW-1:0]        icount_ff;

   // Integration state
   logic signed [QW-1:0] y_ff, y_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [HW-1:0]        time_ff, time_in;
   logic                 sat_ff, sat_in;

   // Working registers
   logic signed [QW-1:0] w_ff, w_in;
   logic signed [QW-1:0] t_ff, t_in;
   logic signed [QW-1:0] f_ff, f_in;
   logic signed [QW-1:0] f1_ff, f1_in;
   logic signed [SW-1:0] s_ff, s_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [79:0]          rsp_data_ff;
   logic                 rsp_last_ff, rsp_sat_ff;
   logic                 rsp_load;

   // Shared multiplier and divider
   uop_type              uop;
   logic signed [QW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [QW-1:0] q;
   logic                 q_ovf;
   logic                 div_start;
   logic [DIV_W-1:0]     quot;
   logic                 div_done;

   // Post-multiply arithmetic
   logic signed [SW-1:0] q_ext, y_ext, beta_ext, f1_ext;
   logic signed [SW-1:0] neg_q, subb, negsum, y_plus_q, y_plus_half;
   logic signed [SW-1:0] s_dbl, s_k4, inc, y_plus_inc;
   logic signed [QW-1:0] neg_sat;
   logic                 time_big;
   logic                 req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign uop = uop_fetch(method_ff, upc_ff);

   // Operand select for the shared multiplier
   always_comb begin
      case (uop.asel)
         A_W:     mul_a = w_ff;
         A_T:     mul_a = t_ff;
         A_ALPHA: mul_a = alpha_ff;
         A_H:     mul_a = $signed({1'b0, h_ff});
         A_HH:    mul_a = $signed({2'b00, h_ff[HW-1:1]});
         default: mul_a = w_ff;
      endcase
      case (uop.bsel)
         B_W:     mul_b = w_ff;
         B_T:     mul_b = t_ff;
         B_F:     mul_b = f_ff;
         B_CNT:   mul_b = $signed({{(QW-CW){1'b0}}, cnt_ff});
         default: mul_b = w_ff;
      endcase
   end

   coi_qmul u_qmul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod),
      .q     (q),
      .q_ovf (q_ovf)
   );

   always_comb begin
      q_ext       = SW'(q);
      y_ext       = SW'(y_ff);
      beta_ext    = SW'(beta_ff);
      f1_ext      = SW'(f1_ff);
      neg_q       = -q_ext;
      neg_sat     = sat32(neg_q);
      subb        = q_ext - beta_ext;
      negsum      = f1_ext + SW'(neg_sat);
      y_plus_q    = y_ext + q_ext;
      y_plus_half = y_ext + (q_ext >>> 1);
      s_dbl       = s_ff + (q_ext <<< 1);
      s_k4        = s_ff + q_ext + RK4_BIAS;
      inc         = $signed({1'b0, quot}) - INC_BIAS;
      y_plus_inc  = y_ext + inc;
      time_big    = |prod[PW-1:HW];
   end

   // Kick the divider with the offset RK4 sum as the fourth k lands
   assign div_start = (state_ff == ST_POST) && (uop.post == P_K4);

   coi_div6 u_div6 (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (s_k4[DIV_W-1:0]),
      .quot  (quot),
      .done  (div_done)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      upc_in   = upc_ff;
      y_in     = y_ff;
      cnt_in   = cnt_ff;
      time_in  = time_ff;
      sat_in   = sat_ff;
      w_in     = w_ff;
      t_in     = t_ff;
      f_in     = f_ff;
      f1_in    = f1_ff;
      s_in     = s_ff;
      rsp_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sat_in = 1'b0;
               if (req_tuser == ACT_LOAD) begin
                  // load: restart the run at index 0
                  y_in     = $signed(req_tdata);
                  cnt_in   = '0;
                  time_in  = '0;
                  state_in = ST_FIN;
               end else if (cnt_ff < icount_ff) begin
                  cnt_in   = cnt_ff + CW'(1);
                  w_in     = y_ff;
                  upc_in   = '0;
                  state_in = ST_MUL;
               end else begin
                  // run finished: repeat the final point
                  state_in = ST_FIN;
               end
            end
         end

         ST_MUL: begin
            state_in = ST_POST;
         end

         ST_POST: begin
            upc_in   = upc_ff + UPC_W'(1);
            state_in = ST_MUL;
            case (uop.post)
               P_SQ: begin
                  t_in   = q;
                  sat_in = sat_ff | q_ovf;
               end
               P_SUBB: begin
                  t_in   = sat32(subb);
                  sat_in = sat_ff | q_ovf | ovf32(subb);
               end
               P_NEG: begin
                  f_in   = neg_sat;
                  sat_in = sat_ff | q_ovf | ovf32(neg_q);
               end
               P_NEGSUM: begin
                  // Heun: fold f1 + f2 into the second derivative
                  f_in   = sat32(negsum);
                  sat_in = sat_ff | q_ovf | ovf32(neg_q) | ovf32(negsum);
               end
               P_YNEW: begin
                  y_in   = sat32(y_plus_q);
                  sat_in = sat_ff | q_ovf | ovf32(y_plus_q);
               end
               P_HEUN1: begin
                  w_in   = sat32(y_plus_q);
                  f1_in  = f_ff;
                  sat_in = sat_ff | q_ovf | ovf32(y_plus_q);
               end
               P_MID1: begin
                  w_in   = sat32(y_plus_q);
                  sat_in = sat_ff | q_ovf | ovf32(y_plus_q);
               end
               P_K1: begin
                  s_in   = q_ext;
                  w_in   = sat32(y_plus_half);
                  sat_in = sat_ff | q_ovf | ovf32(y_plus_half);
               end
               P_K2: begin
                  s_in   = s_dbl;
                  w_in   = sat32(y_plus_half);
                  sat_in = sat_ff | q_ovf | ovf32(y_plus_half);
               end
               P_K3: begin
                  s_in   = s_dbl;
                  w_in   = sat32(y_plus_q);
                  sat_in = sat_ff | q_ovf | ovf32(y_plus_q);
               end
               P_K4: begin
                  sat_in   = sat_ff | q_ovf;
                  state_in = ST_DIV;
               end
               P_TIME: begin
                  time_in = time_big ? T_MAX : prod[HW-1:0];
                  sat_in  = sat_ff | time_big;
               end
               default: begin
                  state_in = ST_MUL;
               end
            endcase
            if (uop.done) state_in = ST_FIN;
         end

         ST_DIV: begin
            // hold until the quotient is in, then apply the RK4 increment
            if (div_done) begin
               y_in     = sat32(y_plus_inc);
               sat_in   = sat_ff | ovf32(y_plus_inc);
               state_in = ST_MUL;
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // Control, state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= '0;
         y_ff         <= '0;
         cnt_ff       <= '0;
         time_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         method_ff    <= METH_RK4;
         alpha_ff     <= '0;
         beta_ff      <= '0;
         h_ff         <= '0;
         icount_ff    <= CW'(1);
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         y_ff         <= y_in;
         cnt_ff       <= cnt_in;
         time_ff      <= time_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_METHOD: method_ff <= csr_wdata[MW-1:0];
               CSR_ALPHA:  alpha_ff  <= $signed(csr_wdata);
               CSR_BETA:   beta_ff   <= $signed(csr_wdata);
               CSR_STEP:   h_ff      <= csr_wdata[HW-1:0];
               CSR_ICOUNT: icount_ff <= csr_wdata[CW-1:0];
               default: begin
                  // drop writes beyond the register list
               end
            endcase
         end
      end
   end

   // Working and output payload
   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      t_ff  <= t_in;
      f_ff  <= f_in;
      f1_ff <= f1_in;
      s_ff  <= s_in;
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, y_ff, time_ff, cnt_ff};
         rsp_last_ff <= (cnt_ff >= icount_ff);
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // A load word lands in y on the next edge
   a_load_y: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == ACT_LOAD) |=> y_ff == $signed($past(req_tdata)))
      else $error("load value not taken into y");

   // The divider reports only while the sequencer waits for it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   // The step index moves only when a word is taken
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> $stable(cnt_ff))
      else $error("step index changed while busy");

   // The micro-op counter never runs past the longest program
   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POST |-> upc_ff <= UPC_LAST)
      else $error("micro-op counter out of range");

endmodule

>>> verif/cooling_ode_integrator_test.sv
// ----------------------------------------------------------------------------
// cooling_ode_integrator_test: self-checking bench for the cooling integrator
// Streams load and step words through the integrator under random stalls on
// both sides and checks every result word against a fixed-point predictor
// of Euler, Heun, midpoint and RK4 kept in step with the register writes.
// ----------------------------------------------------------------------------
module cooling_ode_integrator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import coi_pkg::*;

   // Step word action: everything that is not a load advances the solution
   localparam logic ACT_ADVANCE = ~ACT_LOAD;

   localparam int SETTLE_CYCLES = 4;     // idle gap before a register write
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int TAIL_CYCLES   = 100;   // watch for stray words at the end
   localparam int TOTAL_WORDS   = 1125;  // directed plus random words
   localparam int QUIET_FROM    = 975;   // no idling on either side past this

   // Saturation bounds widened for the 64-bit predictor arithmetic
   localparam longint Q_HI = longint'(Q_MAX);
   localparam longint Q_LO = longint'(Q_MIN);
   localparam longint T_HI = longint'(T_MAX);

   // Q8.24 constants for the directed part
   localparam logic [31:0] Q_ONE     = 32'h0100_0000;
   localparam logic [31:0] Q_TWO     = 32'h0200_0000;
   localparam logic [31:0] Q_SIXTEEN = 32'h1000_0000;
   localparam logic [31:0] Q_MINUS1  = 32'hFF00_0000;

   typedef enum logic [1:0] {PLAN_WORD, PLAN_WRITE, PLAN_DRAIN, PLAN_HOLD} plan_kind_type;

   typedef struct {
      plan_kind_type     kind;
      logic              action;
      logic [31:0]       data;
      logic [CSR_IW-1:0] index;
      bit                quiet;
   } plan_entry_type;

   typedef struct {
      logic [CW-1:0] step_index;
      logic [HW-1:0] time_now;
      logic [QW-1:0] y_value;
      logic          last;
      logic          saturated;
   } point_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;   // [31:0] y_start
   logic              req_tuser  = 1'b0; // [0] action
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [79:0]       rsp_tdata;         // [15:0] step_index, [46:16] time_now,
                                         // [78:47] y_value
   logic              rsp_tlast;         // last
   logic              rsp_tuser;         // [0] saturated
   logic              csr_we     = 1'b0;
   logic [CSR_IW-1:0] csr_index  = '0;
   logic [31:0]       csr_wdata  = '0;

   cooling_ode_integrator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor: shadow registers and solver state, all kept in 64-bit signed
   // arithmetic so every intermediate is exact before it is clipped.
   // -------------------------------------------------------------------------
   logic [MW-1:0] method_cfg;
   longint        alpha_q, beta_q, h_q;
   int            count_cfg;
   longint        y_now, time_acc;
   int            index_now;
   bit            step_sat;

   point_type      expected_points[$];
   plan_entry_type stim_plan[$];

   // Clip to the signed Q8.24 range and remember that it happened
   function automatic longint clip_q(input longint v);
      if (v > Q_HI) begin
         step_sat = 1'b1;
         return Q_HI;
      end
      if (v < Q_LO) begin
         step_sat = 1'b1;
         return Q_LO;
      end
      return v;
   endfunction

   // Q8.24 product: arithmetic shift floors toward minus infinity
   function automatic longint mul_q(input longint a, input longint b);
      return clip_q((a * b) >>> FRAC);
   endfunction

   // dy/dt = -alpha * (y^4 - beta)
   function automatic longint cooling_rate(input longint w);
      longint w2, w4, offset;
      w2     = mul_q(w, w);
      w4     = mul_q(w2, w2);
      offset = clip_q(w4 - beta_q);
      return clip_q(-mul_q(alpha_q, offset));
   endfunction

   // Apply one word to the shadow state and return the point it emits
   function automatic point_type integrate_word(input logic action, input logic [31:0] data);
      point_type p;
      longint h, hh, f1, f2, ye, ym, k1, k2, k3, k4, sum, inc, t;
      step_sat = 1'b0;
      h        = h_q;
      hh       = h_q >>> 1;
      if (action == ACT_LOAD) begin
         y_now     = longint'($signed(data));
         index_now = 0;
         time_acc  = 0;
      end else if (index_now < count_cfg) begin
         case (method_cfg)
            METH_EULER: begin
               y_now = clip_q(y_now + mul_q(h, cooling_rate(y_now)));
            end
            METH_HEUN: begin
               f1    = cooling_rate(y_now);
               ye    = clip_q(y_now + mul_q(h, f1));
               f2    = cooling_rate(ye);
               y_now = clip_q(y_now + mul_q(hh, clip_q(f1 + f2)));
            end
            METH_MID: begin
               ym    = clip_q(y_now + mul_q(hh, cooling_rate(y_now)));
               y_now = clip_q(y_now + mul_q(h, cooling_rate(ym)));
            end
            default: begin
               k1  = mul_q(h, cooling_rate(y_now));
               k2  = mul_q(h, cooling_rate(clip_q(y_now + (k1 >>> 1))));
               k3  = mul_q(h, cooling_rate(clip_q(y_now + (k2 >>> 1))));
               k4  = mul_q(h, cooling_rate(clip_q(y_now + k3)));
               // weighted sum is exact; divide by six rounding down
               sum = k1 + 2 * k2 + 2 * k3 + k4;
               if (sum >= 0) inc = sum / 6;
               else          inc = -((-sum + 5) / 6);
               y_now = clip_q(y_now + inc);
            end
         endcase
         index_now = index_now + 1;
         t = longint'(index_now) * h;
         if (t > T_HI) begin
            t        = T_HI;
            step_sat = 1'b1;
         end
         time_acc = t;
      end
      // past the end of the run the stored point repeats with no saturation
      p.step_index = index_now[CW-1:0];
      p.time_now   = time_acc[HW-1:0];
      p.y_value    = y_now[QW-1:0];
      p.last       = (index_now >= count_cfg);
      p.saturated  = step_sat;
      return p;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus plan
   // -------------------------------------------------------------------------
   int planned_words = 0;
   bit plan_quiet    = 1'b0;

   // Append one entry at the tail of the plan
   task automatic plan_append(input plan_entry_type e);
      stim_plan.insert(stim_plan.size(), e);
   endtask

   task automatic add_word(input logic action, input logic [31:0] data);
      plan_append('{PLAN_WORD, action, data, '0, plan_quiet});
      planned_words++;
   endtask

   task automatic add_write(input logic [CSR_IW-1:0] idx, input logic [31:0] v);
      plan_append('{PLAN_WRITE, 1'b0, v, idx, plan_quiet});
   endtask

   // Sender pauses until every expected word has come back
   task automatic add_drain();
      plan_append('{PLAN_DRAIN, 1'b0, '0, '0, plan_quiet});
   endtask

   task automatic add_hold();
      plan_append('{PLAN_HOLD, 1'b0, '0, '0, plan_quiet});
   endtask

   // Q8.24 value: mostly within +/-span, sometimes an extreme or any pattern
   function automatic logic [31:0] pick_word(input int unsigned span);
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom;
         default: return 32'($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Driver: feed request words and register writes from the plan
   // -------------------------------------------------------------------------
   int   sent_count = 0;
   int   seen_count = 0;
   logic quiet_now  = 1'b0;
   logic hold_kick  = 1'b0;
   int   hold_left  = 0;
   int   gap_left   = 0;
   int   settle_left = 0;
   int   fail_count = 0;

   always @(posedge clock) begin : drive_requests
      logic           next_valid, next_user, next_we, next_kick;
      logic [31:0]    next_data;
      plan_entry_type head;
      next_valid = req_tvalid;
      next_user  = req_tuser;
      next_data  = req_tdata;
      next_we    = 1'b0;
      next_kick  = 1'b0;
      if (reset) begin
         next_valid  = 1'b0;
         gap_left    = 0;
         settle_left = 0;
         method_cfg  = METH_RK4;
         alpha_q     = 0;
         beta_q      = 0;
         h_q         = 0;
         count_cfg   = 1;
         y_now       = 0;
         index_now   = 0;
         time_acc    = 0;
      end else begin
         // predict at acceptance, so the shadow state follows word order
         if (req_tvalid && req_tready) begin
            expected_points.insert(expected_points.size(),
                                   integrate_word(req_tuser, req_tdata));
            sent_count <= sent_count + 1;
            next_valid = 1'b0;
         end
         if (!next_valid && stim_plan.size() != 0) begin
            head = stim_plan[0];
            case (head.kind)
               PLAN_WORD: begin
                  if (gap_left != 0) begin
                     gap_left--;
                  end else if (!head.quiet && $urandom_range(0, 5) == 0) begin
                     gap_left = $urandom_range(0, 2);
                  end else begin
                     next_valid = 1'b1;
                     next_user  = head.action;
                     next_data  = head.data;
                     quiet_now <= head.quiet;
                     void'(stim_plan.pop_front());
                  end
               end
               PLAN_DRAIN: begin
                  // hold off until the block has returned everything
                  if (sent_count != seen_count) begin
                     settle_left = 0;
                  end else if (settle_left < SETTLE_CYCLES) begin
                     settle_left++;
                  end else begin
                     settle_left = 0;
                     void'(stim_plan.pop_front());
                  end
               end
               PLAN_WRITE: begin
                  next_we = 1'b1;
                  csr_index <= head.index;
                  csr_wdata <= head.data;
                  case (head.index)
                     CSR_METHOD: method_cfg = head.data[MW-1:0];
                     CSR_ALPHA:  alpha_q    = longint'($signed(head.data));
                     CSR_BETA:   beta_q     = longint'($signed(head.data));
                     CSR_STEP:   h_q        = longint'(head.data[HW-1:0]);
                     CSR_ICOUNT: count_cfg  = int'(head.data[CW-1:0]);
                     default: ;
                  endcase
                  void'(stim_plan.pop_front());
               end
               default: begin
                  next_kick = 1'b1;
                  void'(stim_plan.pop_front());
               end
            endcase
         end
      end
      req_tvalid <= next_valid;
      req_tuser  <= next_user;
      req_tdata  <= next_data;
      csr_we     <= next_we;
      hold_kick  <= next_kick;
   end

   // Long receiver hold-off, counted on its own so the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check each accepted result word against the oldest prediction
   // -------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin : watch_results
      logic      next_ready;
      bit        bad;
      point_type want;
      next_ready = 1'b0;
      bad        = 1'b0;
      if (reset) begin
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_count <= seen_count + 1;
            if (expected_points.size() == 0) begin
               $error("result word with no prediction pending: %h", rsp_tdata);
               bad = 1'b1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[15:0] !== want.step_index) begin
                  $error("step_index: expected %0d, got %0d",
                         want.step_index, rsp_tdata[15:0]);
                  bad = 1'b1;
               end
               if (rsp_tdata[46:16] !== want.time_now) begin
                  $error("time_now: expected %h, got %h", want.time_now, rsp_tdata[46:16]);
                  bad = 1'b1;
               end
               if (rsp_tdata[78:47] !== want.y_value) begin
                  $error("y_value: expected %h, got %h", want.y_value, rsp_tdata[78:47]);
                  bad = 1'b1;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  bad = 1'b1;
               end
               if (rsp_tuser !== want.saturated) begin
                  $error("saturated: expected %b, got %b", want.saturated, rsp_tuser);
                  bad = 1'b1;
               end
            end
            if (bad) fail_count <= fail_count + 1;
         end
         // ready: drop for the long hold-off, else random short stalls
         if (hold_left != 0) begin
            next_ready = 1'b0;
         end else if (quiet_now) begin
            next_ready = 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_tready <= next_ready;
   end

   // -------------------------------------------------------------------------
   // Plan the run, release reset, wait for the last word and report
   // -------------------------------------------------------------------------
   initial begin : run_plan
      int          phase, runs, steps, i;
      logic [31:0] count_val, h_val;

      // Step before any load integrates from the reset state (RK4, one interval, rest zero)
      add_word(ACT_ADVANCE, $urandom);
      add_word(ACT_ADVANCE, $urandom);

      // Euler, y = 2 sits on the equilibrium; y = 1.5 runs out and repeats
      add_drain();
      add_write(CSR_METHOD, 32'(METH_EULER));
      add_write(CSR_ALPHA,  Q_ONE);
      add_write(CSR_BETA,   Q_SIXTEEN);
      add_write(CSR_STEP,   32'h0010_0000);
      add_write(CSR_ICOUNT, 32'd3);
      add_word(ACT_LOAD, Q_TWO);
      add_word(ACT_LOAD, 32'h0180_0000);
      repeat (4) add_word(ACT_ADVANCE, $urandom);

      // Heun with alpha, beta, step and start value at extremes: products and time overflow
      add_drain();
      add_write(CSR_METHOD, 32'(METH_HEUN));
      add_write(CSR_ALPHA,  32'h7FFF_FFFF);
      add_write(CSR_BETA,   32'h8000_0000);
      add_write(CSR_STEP,   32'h7FFF_FFFF);
      add_write(CSR_ICOUNT, 32'd5);
      add_word(ACT_LOAD, 32'h7FFF_FFFF);
      add_word(ACT_ADVANCE, 32'h0);
      add_word(ACT_ADVANCE, 32'hFFFF_FFFF);
      add_word(ACT_LOAD, 32'h8000_0000);
      add_word(ACT_ADVANCE, $urandom);

      // Midpoint with a zero interval count: the load is already last
      add_drain();
      add_write(CSR_METHOD, 32'(METH_MID));
      add_write(CSR_ICOUNT, 32'd0);
      add_write(CSR_ALPHA,  32'h8000_0000);
      add_write(CSR_BETA,   32'h7FFF_FFFF);
      add_word(ACT_LOAD, Q_MINUS1);
      add_word(ACT_ADVANCE, $urandom);

      // RK4 behind a long receiver hold-off
      add_drain();
      add_write(CSR_METHOD, 32'(METH_RK4));
      add_write(CSR_ICOUNT, 32'd5);
      add_write(CSR_ALPHA,  32'h0080_0000);
      add_write(CSR_BETA,   Q_ONE);
      add_write(CSR_STEP,   32'h0040_0000);
      add_hold();
      add_word(ACT_LOAD, 32'h0133_3333);
      repeat (3) add_word(ACT_ADVANCE, $urandom);

      // Interval count lowered under the running index: run counts as done
      add_drain();
      add_write(CSR_ICOUNT, 32'd2);
      add_word(ACT_ADVANCE, $urandom);

      // Largest interval count
      add_drain();
      add_write(CSR_ICOUNT, 32'hFFFF);
      add_word(ACT_LOAD, 32'h0);
      add_word(ACT_ADVANCE, $urandom);

      // Random phases: new settings each phase, mostly well-formed runs
      phase = 0;
      while (planned_words < TOTAL_WORDS) begin
         plan_quiet = (planned_words >= QUIET_FROM);
         add_drain();
         case ($urandom_range(0, 19))
            0:       count_val = 32'd0;
            1:       count_val = 32'hFFFF;
            2:       count_val = 32'd1;
            default: count_val = $urandom_range(2, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       h_val = 32'd0;
            1:       h_val = 32'h7FFF_FFFF;
            2:       h_val = $urandom & 32'h7FFF_FFFF;
            default: h_val = $urandom_range(0, 32'h0080_0000);
         endcase
         add_write(CSR_METHOD, $urandom_range(0, 3));
         add_write(CSR_ALPHA,  pick_word(32'h0200_0000));
         add_write(CSR_BETA,   pick_word(32'h1000_0000));
         add_write(CSR_STEP,   h_val);
         add_write(CSR_ICOUNT, count_val);
         if (phase == 5) add_hold();
         runs = int'($urandom_range(1, 3));
         repeat (runs) begin
            case ($urandom_range(0, 9))
               0: begin
                  // noise: any action, any data
                  repeat ($urandom_range(1, 4)) add_word(1'($urandom_range(0, 1)), $urandom);
               end
               1: begin
                  // steps with no fresh load
                  repeat ($urandom_range(1, 3)) add_word(ACT_ADVANCE, $urandom);
               end
               default: begin
                  add_word(ACT_LOAD, pick_word(32'h0400_0000));
                  steps = (count_val < 12 ? int'(count_val) : 12)
                          + int'($urandom_range(0, 2));
                  for (i = 0; i < steps; i++) begin
                     add_word(ACT_ADVANCE, $urandom);
                     if ($urandom_range(0, 39) == 0) add_drain();
                  end
               end
            endcase
         end
         phase++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (stim_plan.size() != 0 || req_tvalid || sent_count != seen_count)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_points.size() == 0) begin
         $display("cooling_ode_integrator: match");
      end else begin
         $display("cooling_ode_integrator: mismatch");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run
   initial begin
      #5000000;
      $display("cooling_ode_integrator: mismatch");
      $finish;
   end

endmodule
